>>> rtl/core/gedf_pkg.sv
// ----------------------------------------------------------------------------
// gedf_pkg
// Shared constants and types of the global EDF multicore scheduler.
// ----------------------------------------------------------------------------
package gedf_pkg;
  localparam int NumCpus  = 4;
  localparam int MaxTasks = 16;
  localparam int SlotW    = $clog2(MaxTasks);
  localparam int CpuW     = 2;
  localparam int IdW      = 8;
  localparam int DlW      = 32;
  localparam int BurstW   = 16;
  localparam int TimeW    = 32;
  localparam int EntryW   = DlW + IdW + BurstW + 1;

  typedef struct packed {
    logic [DlW-1:0]    deadline;
    logic [IdW-1:0]    task_id;
    logic [BurstW-1:0] remaining;
    logic              started;
  } entry_t;

  typedef struct packed {
    logic             busy;
    logic [SlotW-1:0] slot;
  } assign_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ARR, ST_RET_RD, ST_RET_WB, ST_RANK_RD, ST_RANK_CMP, ST_RANK_END,
    ST_EXE_RD, ST_EXE_WB, ST_PRE_RD, ST_REPORT
  } state_e;
endpackage

>>> rtl/core/gedf_ram.sv
// ----------------------------------------------------------------------------
// gedf_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module gedf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> rtl/core/global_edf_multicore_scheduler.sv
// Arrival: accepted in idle, one acknowledge beat on the next cycle.
// Tick: a retire pass over the CPUs, then k rank passes over all slots, then an
// execute and preempt pass over the CPUs, then NumCpus report beats, one per cycle.
// The rank pass reads each slot in turn for each of the k ranked CPUs (k = active CPUs,
// fewer when tasks run out). The receiver cannot stall. busy stays high until the last beat.
// Reset clears valid flags, CPU assignments, time and sets active_cpus to 4.
// ----------------------------------------------------------------------------
// global_edf_multicore_scheduler
// Top level: sequencer around the task-slot RAM.
// ----------------------------------------------------------------------------
module global_edf_multicore_scheduler (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_data_i,
  input  logic                   op_i,
  input  logic [gedf_pkg::IdW-1:0]    task_id_i,
  input  logic [gedf_pkg::DlW-1:0]    task_deadline_i,
  input  logic [gedf_pkg::BurstW-1:0] task_burst_i,
  output logic                   strobe,
  output logic                   kind_o,
  output logic                   accepted_o,
  output logic [1:0]             cpu_index_o,
  output logic                   finished_valid_o,
  output logic [gedf_pkg::IdW-1:0]    finished_id_o,
  output logic                   run_valid_o,
  output logic [gedf_pkg::IdW-1:0]    run_id_o,
  output logic                   first_start_o,
  output logic                   preempted_valid_o,
  output logic [gedf_pkg::IdW-1:0]    preempted_id_o,
  output logic [gedf_pkg::TimeW-1:0]  tick_time_o,
  output logic                   last_o
);
  import gedf_pkg::*;

  state_e state_q, state_d;
  logic [MaxTasks-1:0] valid_q, valid_d, chosen_q, chosen_d;
  assign_t asg_q [NumCpus];
  assign_t asg_d [NumCpus];
  assign_t prev_q [NumCpus];
  assign_t prev_d [NumCpus];
  assign_t next_q [NumCpus];
  assign_t next_d [NumCpus];
  logic [NumCpus-1:0] fin_v_q, fin_v_d, first_q, first_d;
  logic [IdW-1:0] fin_id_q [NumCpus];
  logic [IdW-1:0] fin_id_d [NumCpus];
  logic [IdW-1:0] run_id_q [NumCpus];
  logic [IdW-1:0] run_id_d [NumCpus];
  logic [IdW-1:0] pre_id_q [NumCpus];
  logic [IdW-1:0] pre_id_d [NumCpus];
  logic [TimeW-1:0] time_q, time_d;
  logic [2:0] acpu_q;
  logic [CpuW-1:0] cpu_q, cpu_d;
  logic [SlotW:0] scan_q, scan_d;
  logic best_v_q, best_v_d;
  logic [SlotW-1:0] best_q, best_d;
  logic [DlW-1:0] best_dl_q, best_dl_d;
  logic [IdW-1:0] best_id_q, best_id_d;
  logic acc_q, acc_d;
  logic [2:0] keff;

  logic we;
  logic [SlotW-1:0] addr;
  entry_t wdata, rdata;
  logic [EntryW-1:0] rbits;
  assign rdata = entry_t'(rbits);

  gedf_ram #(.Width(EntryW), .Depth(MaxTasks)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rbits)
  );

  logic free_found;
  logic [SlotW-1:0] free_slot;
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = MaxTasks - 1; s >= 0; s--) begin
      if (!valid_q[s]) begin
        free_found = 1'b1;
        free_slot  = SlotW'(s);
      end
    end
  end

  always_comb begin
    keff = acpu_q;
    if (keff == 3'd0) keff = 3'd1;
    if (keff > 3'(NumCpus)) keff = 3'(NumCpus);
  end

  // report beats stream out after the last CPU is resolved
  logic rep_q;
  logic [CpuW-1:0] rep_cpu_q;
  logic [TimeW-1:0] rep_time_q;
  logic beats;

  assign busy        = (state_q != ST_IDLE) || rep_q;
  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
      time_q  <= '0;
      acpu_q  <= 3'd4;
      for (int c = 0; c < NumCpus; c++) asg_q[c] <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      time_q  <= time_d;
      asg_q   <= asg_d;
      if (cfg_valid_i && cfg_ready_o) acpu_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    chosen_q <= chosen_d; prev_q <= prev_d; next_q <= next_d;
    fin_v_q <= fin_v_d; first_q <= first_d; fin_id_q <= fin_id_d;
    run_id_q <= run_id_d; pre_id_q <= pre_id_d; cpu_q <= cpu_d;
    scan_q <= scan_d; best_v_q <= best_v_d; best_q <= best_d;
    best_dl_q <= best_dl_d; best_id_q <= best_id_d; acc_q <= acc_d;
  end

  always_comb begin
    state_d = state_q; valid_d = valid_q; time_d = time_q; asg_d = asg_q;
    chosen_d = chosen_q; prev_d = prev_q; next_d = next_q;
    fin_v_d = fin_v_q; first_d = first_q; fin_id_d = fin_id_q;
    run_id_d = run_id_q; pre_id_d = pre_id_q; cpu_d = cpu_q;
    scan_d = scan_q; best_v_d = best_v_q; best_d = best_q;
    best_dl_d = best_dl_q; best_id_d = best_id_q; acc_d = acc_q;
    we = 1'b0; addr = '0; wdata = rdata;
    unique case (state_q)
      ST_IDLE: begin
        if (start && !rep_q) begin
          if (!op_i) begin
            acc_d = free_found;
            if (free_found) begin
              we = 1'b1; addr = free_slot;
              wdata.deadline  = task_deadline_i;
              wdata.task_id   = task_id_i;
              wdata.remaining = (task_burst_i == '0) ? BurstW'(1) : task_burst_i;
              wdata.started   = 1'b0;
              valid_d[free_slot] = 1'b1;
            end
            state_d = ST_ARR;
          end else begin
            cpu_d = '0; fin_v_d = '0; first_d = '0;
            chosen_d = '0;
            state_d = ST_RET_RD;
          end
        end
      end
      ST_ARR: state_d = ST_IDLE;
      ST_RET_RD: begin
        addr = asg_q[cpu_q].slot;
        if (asg_q[cpu_q].busy && !valid_q[asg_q[cpu_q].slot])
          asg_d[cpu_q].busy = 1'b0;
        state_d = ST_RET_WB;
      end
      ST_RET_WB: begin
        fin_id_d[cpu_q] = '0;
        if (asg_q[cpu_q].busy && rdata.remaining == '0) begin
          fin_v_d[cpu_q] = 1'b1; fin_id_d[cpu_q] = rdata.task_id;
          valid_d[asg_q[cpu_q].slot] = 1'b0;
          asg_d[cpu_q].busy = 1'b0;
        end
        prev_d[cpu_q] = asg_d[cpu_q];
        next_d[cpu_q] = '0;
        if (cpu_q == CpuW'(NumCpus - 1)) begin
          cpu_d = '0; scan_d = '0; best_v_d = 1'b0;
          state_d = ST_RANK_RD;
        end else begin
          cpu_d = cpu_q + 1'b1; state_d = ST_RET_RD;
        end
      end
      ST_RANK_RD: begin
        addr = scan_q[SlotW-1:0];
        state_d = ST_RANK_CMP;
      end
      ST_RANK_CMP: begin
        if (valid_q[scan_q[SlotW-1:0]] && !chosen_q[scan_q[SlotW-1:0]] &&
            (!best_v_q || rdata.deadline < best_dl_q ||
             (rdata.deadline == best_dl_q && rdata.task_id < best_id_q))) begin
          best_v_d = 1'b1; best_d = scan_q[SlotW-1:0];
          best_dl_d = rdata.deadline; best_id_d = rdata.task_id;
        end
        scan_d = scan_q + 1'b1;
        state_d = (scan_q == (SlotW+1)'(MaxTasks - 1)) ? ST_RANK_END : ST_RANK_RD;
      end
      ST_RANK_END: begin
        if (best_v_q) begin
          chosen_d[best_q] = 1'b1;
          next_d[cpu_q] = '{busy: 1'b1, slot: best_q};
        end
        scan_d = '0; best_v_d = 1'b0;
        if (!best_v_q || {1'b0, cpu_q} + 3'd1 >= keff) begin
          cpu_d = '0; state_d = ST_EXE_RD;
        end else begin
          cpu_d = cpu_q + 1'b1; state_d = ST_RANK_RD;
        end
      end
      ST_EXE_RD: begin
        addr = next_q[cpu_q].slot;
        state_d = ST_EXE_WB;
      end
      ST_EXE_WB: begin
        run_id_d[cpu_q] = '0;
        if (next_q[cpu_q].busy) begin
          addr = next_q[cpu_q].slot; we = 1'b1;
          run_id_d[cpu_q] = rdata.task_id;
          first_d[cpu_q] = !rdata.started;
          wdata.started = 1'b1;
          if (rdata.remaining != '0) wdata.remaining = rdata.remaining - 1'b1;
        end
        state_d = ST_PRE_RD;
      end
      ST_PRE_RD: begin
        addr = prev_q[cpu_q].slot;
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        pre_id_d[cpu_q] = '0;
        if (prev_q[cpu_q].busy && !chosen_q[prev_q[cpu_q].slot])
          pre_id_d[cpu_q] = rdata.task_id;
        asg_d[cpu_q] = next_q[cpu_q];
        if (cpu_q == CpuW'(NumCpus - 1)) begin
          cpu_d = '0; time_d = time_q + 1'b1; state_d = ST_IDLE;
        end else begin
          cpu_d = cpu_q + 1'b1; state_d = ST_EXE_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign beats = (state_q == ST_REPORT) && (cpu_q == CpuW'(NumCpus - 1));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_q <= 1'b0; rep_cpu_q <= '0;
    end else if (beats) begin
      rep_q <= 1'b1; rep_cpu_q <= '0;
    end else if (rep_q) begin
      rep_cpu_q <= rep_cpu_q + 1'b1;
      if (rep_cpu_q == CpuW'(NumCpus - 1)) rep_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (beats) rep_time_q <= time_q;
  end

  logic [NumCpus-1:0] pre_v;
  always_comb begin
    for (int c = 0; c < NumCpus; c++)
      pre_v[c] = prev_q[c].busy && !chosen_q[prev_q[c].slot];
  end

  // beat outputs; busy stays high while beats drain
  logic arr_beat;
  assign arr_beat = (state_q == ST_ARR);
  always_comb begin
    strobe = arr_beat || rep_q;
    kind_o = rep_q;
    accepted_o = arr_beat && acc_q;
    cpu_index_o = rep_q ? rep_cpu_q : '0;
    finished_valid_o = rep_q && fin_v_q[rep_cpu_q];
    finished_id_o = rep_q ? fin_id_q[rep_cpu_q] : '0;
    run_valid_o = rep_q && next_q[rep_cpu_q].busy;
    run_id_o = rep_q ? run_id_q[rep_cpu_q] : '0;
    first_start_o = rep_q && next_q[rep_cpu_q].busy && first_q[rep_cpu_q];
    preempted_valid_o = rep_q && pre_v[rep_cpu_q];
    preempted_id_o = (rep_q && pre_v[rep_cpu_q]) ? pre_id_q[rep_cpu_q] : '0;
    tick_time_o = rep_q ? rep_time_q : time_q;
    last_o = arr_beat || (rep_q && rep_cpu_q == CpuW'(NumCpus - 1));
  end
endmodule

>>> rtl/core/gedf_checker.sv
// ----------------------------------------------------------------------------
// gedf_checker
// Port-level assertions for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module gedf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic kind_o,
  input logic accepted_o,
  input logic run_valid_o,
  input logic first_start_o,
  input logic last_o
);
  a_arr_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && !kind_o |-> last_o) else $error("ack without last");
  a_acc_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accepted_o |-> strobe && !kind_o) else $error("accepted on tick beat");
  a_first_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_start_o |-> run_valid_o) else $error("first start while idle");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("start not taken");
endmodule

bind global_edf_multicore_scheduler gedf_checker u_gedf_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .strobe(strobe),
  .kind_o(kind_o), .accepted_o(accepted_o), .run_valid_o(run_valid_o),
  .first_start_o(first_start_o), .last_o(last_o)
);

>>> dv/global_edf_multicore_scheduler_checker.sv
// ----------------------------------------------------------------------------
// global_edf_multicore_scheduler_checker
// Watches the command, configuration and result channels of the EDF scheduler,
// keeps its own copy of the task table and CPU map, predicts the beats each
// accepted command causes and compares them field by field.
// ----------------------------------------------------------------------------
module global_edf_multicore_scheduler_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_o,
  input  logic [2:0]                  cfg_data_i,
  input  logic                        op_i,
  input  logic [gedf_pkg::IdW-1:0]    task_id_i,
  input  logic [gedf_pkg::DlW-1:0]    task_deadline_i,
  input  logic [gedf_pkg::BurstW-1:0] task_burst_i,
  input  logic                        strobe,
  input  logic                        kind_o,
  input  logic                        accepted_o,
  input  logic [1:0]                  cpu_index_o,
  input  logic                        finished_valid_o,
  input  logic [gedf_pkg::IdW-1:0]    finished_id_o,
  input  logic                        run_valid_o,
  input  logic [gedf_pkg::IdW-1:0]    run_id_o,
  input  logic                        first_start_o,
  input  logic                        preempted_valid_o,
  input  logic [gedf_pkg::IdW-1:0]    preempted_id_o,
  input  logic [gedf_pkg::TimeW-1:0]  tick_time_o,
  input  logic                        last_o,
  output int                          fail_count_o,
  output int                          pending_o,
  output logic                        beat_o
);
  import gedf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Idle = MaxTasks;

  typedef struct packed {
    logic             kind;
    logic             accepted;
    logic [1:0]       cpu;
    logic             fin_v;
    logic [IdW-1:0]   fin_id;
    logic             run_v;
    logic [IdW-1:0]   run_id;
    logic             first;
    logic             pre_v;
    logic [IdW-1:0]   pre_id;
    logic [TimeW-1:0] tick_time;
    logic             last;
  } report_t;

  logic              live     [MaxTasks];
  logic [DlW-1:0]    dline    [MaxTasks];
  logic [IdW-1:0]    tid      [MaxTasks];
  logic [BurstW-1:0] work_left[MaxTasks];
  logic              ran      [MaxTasks];
  int                on_cpu   [NumCpus];
  logic [TimeW-1:0]  now;
  logic [2:0]        cpus_cfg;
  report_t           sched_q[$];
  int                fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = sched_q.size();

  function automatic bit more_urgent(int a, int b);
    if (dline[a] != dline[b]) return dline[a] < dline[b];
    if (tid[a] != tid[b]) return tid[a] < tid[b];
    return a < b;
  endfunction

  function automatic void schedule_command(logic op, logic [IdW-1:0] id,
                                           logic [DlW-1:0] dl, logic [BurstW-1:0] burst);
    report_t r;
    int      prev[NumCpus];
    int      next[NumCpus];
    bit      chosen[MaxTasks];
    int      k;
    int      best;
    int      a;
    r = '0;
    if (op == 1'b0) begin
      for (int s = 0; s < MaxTasks; s++) begin
        if (!live[s]) begin
          live[s] = 1'b1;
          tid[s] = id;
          dline[s] = dl;
          work_left[s] = (burst == '0) ? BurstW'(1) : burst;
          ran[s] = 1'b0;
          r.accepted = 1'b1;
          break;
        end
      end
      r.tick_time = now;
      r.last = 1'b1;
      sched_q = {sched_q, r};
      return;
    end
    k = (cpus_cfg == 0) ? 1 : ((cpus_cfg > NumCpus) ? NumCpus : int'(cpus_cfg));
    for (int c = 0; c < NumCpus; c++) begin
      chosen[c] = 1'b0;
    end
    for (int s = 0; s < MaxTasks; s++) chosen[s] = 1'b0;
    for (int c = 0; c < NumCpus; c++) begin
      a = on_cpu[c];
      if (a != Idle && !live[a]) a = Idle;
      prev[c] = a;
      next[c] = Idle;
    end
    for (int r_i = 0; r_i < k; r_i++) begin
      best = Idle;
      for (int s = 0; s < MaxTasks; s++) begin
        if (live[s] && !chosen[s] && (best == Idle || more_urgent(s, best))) best = s;
      end
      if (best == Idle) break;
      chosen[best] = 1'b1;
      next[r_i] = best;
    end
    // retire happens before ranking; the ranking is redone after the retirements
    begin
      report_t fin[NumCpus];
      for (int c = 0; c < NumCpus; c++) begin
        fin[c] = '0;
        a = prev[c];
        if (a != Idle && work_left[a] == '0) begin
          fin[c].fin_v = 1'b1;
          fin[c].fin_id = tid[a];
          live[a] = 1'b0;
          prev[c] = Idle;
        end
      end
      for (int s = 0; s < MaxTasks; s++) chosen[s] = 1'b0;
      for (int c = 0; c < NumCpus; c++) next[c] = Idle;
      for (int r_i = 0; r_i < k; r_i++) begin
        best = Idle;
        for (int s = 0; s < MaxTasks; s++) begin
          if (live[s] && !chosen[s] && (best == Idle || more_urgent(s, best))) best = s;
        end
        if (best == Idle) break;
        chosen[best] = 1'b1;
        next[r_i] = best;
      end
      for (int c = 0; c < NumCpus; c++) begin
        r = fin[c];
        r.kind = 1'b1;
        r.cpu = 2'(c);
        if (next[c] != Idle) begin
          r.run_v = 1'b1;
          r.run_id = tid[next[c]];
          r.first = !ran[next[c]];
          ran[next[c]] = 1'b1;
          if (work_left[next[c]] != '0) work_left[next[c]]--;
        end
        if (prev[c] != Idle && !chosen[prev[c]]) begin
          r.pre_v = 1'b1;
          r.pre_id = tid[prev[c]];
        end
        r.tick_time = now;
        r.last = (c == NumCpus - 1);
        on_cpu[c] = next[c];
        sched_q = {sched_q, r};
      end
    end
    now++;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    report_t exp_r;
    if (!rst_ni) begin
      for (int s = 0; s < MaxTasks; s++) begin
        live[s] = 1'b0;
        dline[s] = '0;
        tid[s] = '0;
        work_left[s] = '0;
        ran[s] = 1'b0;
      end
      for (int c = 0; c < NumCpus; c++) on_cpu[c] = Idle;
      now = '0;
      cpus_cfg = 3'd4;
      sched_q.delete();
      beat_o <= 1'b0;
    end else begin
      beat_o <= strobe || (start && !busy) || (cfg_valid_i && cfg_ready_o);
      if (strobe) begin
        if (sched_q.size() == 0) begin
          $display("%0t: unexpected report beat, actual kind %0h cpu %0h",
                   $realtime, kind_o, cpu_index_o);
          fails++;
        end else begin
          exp_r = sched_q.pop_front();
          check_field("kind", exp_r.kind, kind_o);
          check_field("accepted", exp_r.accepted, accepted_o);
          check_field("cpu_index", exp_r.cpu, cpu_index_o);
          check_field("finished_valid", exp_r.fin_v, finished_valid_o);
          check_field("finished_id", exp_r.fin_id, finished_id_o);
          check_field("run_valid", exp_r.run_v, run_valid_o);
          check_field("run_id", exp_r.run_id, run_id_o);
          check_field("first_start", exp_r.first, first_start_o);
          check_field("preempted_valid", exp_r.pre_v, preempted_valid_o);
          check_field("preempted_id", exp_r.pre_id, preempted_id_o);
          check_field("tick_time", exp_r.tick_time, tick_time_o);
          check_field("last", exp_r.last, last_o);
        end
      end
      if (cfg_valid_i && cfg_ready_o) cpus_cfg = cfg_data_i;
      if (start && !busy) schedule_command(op_i, task_id_i, task_deadline_i, task_burst_i);
    end
  end
endmodule

>>> dv/global_edf_multicore_scheduler_tb.sv
// ----------------------------------------------------------------------------
// global_edf_multicore_scheduler_tb
// Drives directed and random arrival and tick commands with random gaps
// through several active-CPU settings, including the out-of-range ones;
// the checker predicts and compares every report beat.
// ----------------------------------------------------------------------------
module global_edf_multicore_scheduler_tb;
  import gedf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OpArrive = 1'b0;
  localparam logic OpTick   = 1'b1;
  localparam int   WatchdogLimit = 5000;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [2:0]        cfg_data_i;
  logic              op_i;
  logic [IdW-1:0]    task_id_i;
  logic [DlW-1:0]    task_deadline_i;
  logic [BurstW-1:0] task_burst_i;
  logic              strobe;
  logic              kind_o;
  logic              accepted_o;
  logic [1:0]        cpu_index_o;
  logic              finished_valid_o;
  logic [IdW-1:0]    finished_id_o;
  logic              run_valid_o;
  logic [IdW-1:0]    run_id_o;
  logic              first_start_o;
  logic              preempted_valid_o;
  logic [IdW-1:0]    preempted_id_o;
  logic [TimeW-1:0]  tick_time_o;
  logic              last_o;
  int                fail_count;
  int                pending;
  logic              beat;
  int                ticks_sent;
  int                idle_cycles = 0;

  global_edf_multicore_scheduler i_dut (.*);

  global_edf_multicore_scheduler_checker i_checker (
    .*,
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .beat_o      (beat)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    idle_cycles <= beat ? 0 : idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_command(logic op, logic [IdW-1:0] id, logic [DlW-1:0] dl,
                              logic [BurstW-1:0] burst);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    op_i            <= op;
    task_id_i       <= id;
    task_deadline_i <= dl;
    task_burst_i    <= burst;
    do @(posedge clk_i); while (busy);
    if (op == OpTick) ticks_sent++;
  endtask

  task automatic write_cpus(logic [2:0] value);
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_command();
    logic [DlW-1:0]    dl;
    logic [BurstW-1:0] burst;
    int                pick;
    pick = $urandom_range(0, 99);
    dl = (pick < 60) ? DlW'(ticks_sent + $urandom_range(0, 40)) : DlW'($urandom);
    pick = $urandom_range(0, 99);
    burst = (pick < 95) ? BurstW'($urandom_range(0, 6)) : BurstW'($urandom);
    if ($urandom_range(0, 99) < 50) send_command(OpArrive, IdW'($urandom), dl, burst);
    else send_command(OpTick, IdW'($urandom), DlW'($urandom), BurstW'($urandom));
  endtask

  initial begin
    logic [2:0] cpu_settings[8] = '{3'd1, 3'd0, 3'd7, 3'd4, 3'd2, 3'd3, 3'd5, 3'd6};
    ticks_sent      = 0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    op_i            = OpArrive;
    task_id_i       = '0;
    task_deadline_i = '0;
    task_burst_i    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(OpTick, '0, '0, '0);
    send_command(OpArrive, 8'd0, 32'd0, 16'h0000);
    send_command(OpArrive, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_command(OpArrive, 8'd5, 32'd10, 16'd1);
    send_command(OpArrive, 8'd5, 32'd10, 16'd2);
    send_command(OpArrive, 8'd3, 32'd10, 16'd2);
    send_command(OpTick, '1, '1, '1);
    send_command(OpTick, '0, '0, '0);
    send_command(OpArrive, 8'd1, 32'd1, 16'd3);
    send_command(OpTick, '0, '0, '0);
    for (int i = 0; i < 13; i++) begin
      send_command(OpArrive, IdW'(i + 20), DlW'(i + 5), BurstW'(1 + i % 3));
    end
    send_command(OpTick, '0, '0, '0);
    send_command(OpTick, '0, '0, '0);

    foreach (cpu_settings[p]) begin
      write_cpus(cpu_settings[p]);
      for (int i = 0; i < 44; i++) random_command();
    end

    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (150) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
